// ===== rtl/core/speck_pkg.sv =====
// Shared types, constants and round functions of the Speck block cipher.
package speck_pkg;

    localparam int SMALL_ROUNDS = 22;
    localparam int LARGE_ROUNDS = 34;

    localparam int SMALL_BITS = 16;
    localparam int LARGE_BITS = 64;

    localparam int SMALL_ROT_A = 7;
    localparam int SMALL_ROT_B = 2;
    localparam int LARGE_ROT_A = 8;
    localparam int LARGE_ROT_B = 3;

    // configuration register indexes
    localparam logic [2:0] REG_VARIANT = 3'd0;
    localparam logic [2:0] REG_DECRYPT = 3'd1;
    localparam logic [2:0] REG_KEY_0   = 3'd2;
    localparam logic [2:0] REG_KEY_1   = 3'd3;
    localparam logic [2:0] REG_KEY_2   = 3'd4;
    localparam logic [2:0] REG_KEY_3   = 3'd5;
    localparam logic [2:0] NUM_REGS    = 3'd6;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
    } speck_pair_t;

    // keep the low word only in the small variant
    function automatic logic [63:0] mask_word(input logic big, input logic [63:0] v);
        return big ? v : {48'd0, v[15:0]};
    endfunction

    // forward round; with x = l0, y = k and key = step it is also the key schedule step
    function automatic speck_pair_t enc_round(input logic big, input logic [63:0] x,
                                              input logic [63:0] y, input logic [63:0] k);
        speck_pair_t r;
        logic [63:0] xr;
        logic [15:0] xs;
        logic [15:0] nxs;
        xr = (x >> LARGE_ROT_A) | (x << (LARGE_BITS - LARGE_ROT_A));
        xs = (x[15:0] >> SMALL_ROT_A) | (x[15:0] << (SMALL_BITS - SMALL_ROT_A));
        nxs = (xs + y[15:0]) ^ k[15:0];
        if (big)
        begin
            r.x = (xr + y) ^ k;
            r.y = ((y << LARGE_ROT_B) | (y >> (LARGE_BITS - LARGE_ROT_B))) ^ r.x;
        end
        else
        begin
            r.x = {48'd0, nxs};
            r.y = {48'd0, ((y[15:0] << SMALL_ROT_B)
                          | (y[15:0] >> (SMALL_BITS - SMALL_ROT_B))) ^ nxs};
        end
        return r;
    endfunction

    // inverse round
    function automatic speck_pair_t dec_round(input logic big, input logic [63:0] x,
                                              input logic [63:0] y, input logic [63:0] k);
        speck_pair_t r;
        logic [63:0] t;
        logic [63:0] ny;
        logic [63:0] d;
        logic [15:0] ts;
        logic [15:0] nys;
        logic [15:0] ds;
        t   = x ^ y;
        ny  = (t >> LARGE_ROT_B) | (t << (LARGE_BITS - LARGE_ROT_B));
        d   = (x ^ k) - ny;
        ts  = x[15:0] ^ y[15:0];
        nys = (ts >> SMALL_ROT_B) | (ts << (SMALL_BITS - SMALL_ROT_B));
        ds  = (x[15:0] ^ k[15:0]) - nys;
        if (big)
        begin
            r.y = ny;
            r.x = (d << LARGE_ROT_A) | (d >> (LARGE_BITS - LARGE_ROT_A));
        end
        else
        begin
            r.y = {48'd0, nys};
            r.x = {48'd0, (ds << SMALL_ROT_A) | (ds >> (SMALL_BITS - SMALL_ROT_A))};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/speck_block_cipher.sv =====
// Top level of the Speck 32/64 and 128/256 block cipher with a RAM-held key schedule.
//
// One block (block_x, block_y) is taken per input transfer and one result is returned
// per block. The rounds run on one shared round unit, one round per cycle, with each
// round key read from the key RAM in the cycle before its round. After its transfer a
// block passes through a state that issues the first key read, then the n rounds, where n
// is 22 for the 32/64 variant and 34 for 128/256 (both capped at ROUND_KEY_DEPTH), then
// a state that loads the output register. The first block after reset or after a write
// to a known configuration register first runs the key schedule, one key per cycle
// through the same round unit. The next block is taken once the result has moved to the
// output register, so a waiting result does not hold up the next transfer. In the 32/64
// variant only the low 16 bits of keys and blocks are used and results are zero-extended.
// Write configuration only while the block is idle.
module speck_block_cipher import speck_pkg::*; #(
    parameter int ROUND_KEY_DEPTH = 34
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_x,
    input  logic [63:0] block_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_x,
    output logic [63:0] result_y
);

    localparam int AW      = $clog2(ROUND_KEY_DEPTH);
    localparam int SMALL_N = (SMALL_ROUNDS < ROUND_KEY_DEPTH) ? SMALL_ROUNDS : ROUND_KEY_DEPTH;
    localparam int LARGE_N = (LARGE_ROUNDS < ROUND_KEY_DEPTH) ? LARGE_ROUNDS : ROUND_KEY_DEPTH;
    localparam logic [AW-1:0] SMALL_LAST = AW'(SMALL_N - 1);
    localparam logic [AW-1:0] LARGE_LAST = AW'(LARGE_N - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic          keys_ready_reg, keys_ready_next;
    logic          out_valid_reg, out_valid_next;
    logic          variant_reg, decrypt_reg;
    logic [63:0]   key_reg [4];
    logic [AW-1:0] idx_reg, idx_next;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   y_reg, y_next;
    logic [63:0]   k_reg, k_next;
    logic [63:0]   l0_reg, l0_next;
    logic [63:0]   l1_reg, l1_next;
    logic [63:0]   l2_reg, l2_next;
    logic [63:0]   res_x_reg, res_x_next;
    logic [63:0]   res_y_reg, res_y_next;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    logic [AW-1:0] last_idx;
    logic [AW-1:0] step_idx;
    logic          in_xfer;
    logic          expanding;
    logic [63:0]   unit_x, unit_y, unit_k;
    speck_pair_t   enc_out, dec_out, round_out;

    speck_ram #(
        .WIDTH (64),
        .DEPTH (ROUND_KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (k_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign result_x  = res_x_reg;
    assign result_y  = res_y_reg;
    assign last_idx  = variant_reg ? LARGE_LAST : SMALL_LAST;
    assign expanding = (state_reg == ST_EXPAND);

    // shared round unit: key schedule step while expanding, cipher round otherwise
    assign unit_x    = expanding ? l0_reg : x_reg;
    assign unit_y    = expanding ? k_reg : y_reg;
    assign unit_k    = expanding ? 64'(idx_reg) : ram_rdata;
    assign enc_out   = enc_round(variant_reg, unit_x, unit_y, unit_k);
    assign dec_out   = dec_round(variant_reg, x_reg, y_reg, ram_rdata);
    assign round_out = (!expanding && decrypt_reg) ? dec_out : enc_out;

    always_comb
    begin
        state_next      = state_reg;
        keys_ready_next = keys_ready_reg;
        out_valid_next  = out_valid_reg;
        idx_next        = idx_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        k_next          = k_reg;
        l0_next         = l0_reg;
        l1_next         = l1_reg;
        l2_next         = l2_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        step_idx        = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_next = mask_word(variant_reg, block_x);
                    y_next = mask_word(variant_reg, block_y);
                    if (keys_ready_reg)
                    begin
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        k_next     = mask_word(variant_reg, key_reg[0]);
                        l0_next    = mask_word(variant_reg, key_reg[1]);
                        l1_next    = mask_word(variant_reg, key_reg[2]);
                        l2_next    = mask_word(variant_reg, key_reg[3]);
                        idx_next   = '0;
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                // store this round key, then advance the schedule
                ram_we = 1'b1;
                if (idx_reg == last_idx)
                begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_PRIME;
                end
                else
                begin
                    k_next   = round_out.y;
                    l0_next  = l1_reg;
                    l1_next  = l2_reg;
                    l2_next  = round_out.x;
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_PRIME:
            begin
                step_idx   = decrypt_reg ? last_idx : '0;
                ram_re     = 1'b1;
                ram_raddr  = step_idx;
                idx_next   = step_idx;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                x_next = round_out.x;
                y_next = round_out.y;
                if (decrypt_reg ? (idx_reg == '0) : (idx_reg == last_idx))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // fetch the key of the following round
                    step_idx  = decrypt_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                    ram_re    = 1'b1;
                    ram_raddr = step_idx;
                    idx_next  = step_idx;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_x_next     = x_reg;
                    res_y_next     = y_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // any known register write invalidates the expanded keys
        if (cfg_we && (cfg_index < NUM_REGS))
        begin
            keys_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= 1'b0;
            decrypt_reg <= 1'b0;
            key_reg[0]  <= '0;
            key_reg[1]  <= '0;
            key_reg[2]  <= '0;
            key_reg[3]  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VARIANT: variant_reg <= cfg_data[0];
                REG_DECRYPT: decrypt_reg <= cfg_data[0];
                REG_KEY_0:   key_reg[0]  <= cfg_data;
                REG_KEY_1:   key_reg[1]  <= cfg_data;
                REG_KEY_2:   key_reg[2]  <= cfg_data;
                REG_KEY_3:   key_reg[3]  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        k_reg     <= k_next;
        l0_reg    <= l0_next;
        l1_reg    <= l1_next;
        l2_reg    <= l2_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
    end

endmodule

// ===== rtl/core/speck_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module speck_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/speck_block_cipher_checker.sv =====
// Checker for the Speck block cipher: watches the channels, predicts each result and compares.
module speck_block_cipher_checker import speck_pkg::*; #(
    parameter int ROUND_KEY_DEPTH = 34
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] block_x,
    input  logic [63:0] block_y,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] result_x,
    input  logic [63:0] result_y,
    output int          fail_count,
    output int          pending
);

    localparam int PRINT_LIMIT = 100;

    logic        wide_mode;
    logic        decipher;
    logic [63:0] key_word [4];
    logic [63:0] sched [ROUND_KEY_DEPTH];
    logic        sched_valid;
    speck_pair_t cipher_results_due [$];

    function automatic logic [63:0] word_mask(input logic wide);
        return wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_0000_FFFF;
    endfunction

    function automatic int round_count(input logic wide);
        int n;
        n = wide ? LARGE_ROUNDS : SMALL_ROUNDS;
        return (n < ROUND_KEY_DEPTH) ? n : ROUND_KEY_DEPTH;
    endfunction

    function automatic logic [63:0] rot_left(input logic wide, input logic [63:0] v,
                                             input int r);
        logic [63:0] d;
        logic [15:0] w;
        if (wide)
        begin
            d = (v << r) | (v >> (LARGE_BITS - r));
            return d;
        end
        // rotate within the 16-bit word, then zero-extend
        w = v[15:0];
        w = (w << r) | (w >> (SMALL_BITS - r));
        return {48'd0, w};
    endfunction

    function automatic logic [63:0] rot_right(input logic wide, input logic [63:0] v,
                                              input int r);
        return rot_left(wide, v, (wide ? LARGE_BITS : SMALL_BITS) - r);
    endfunction

    function automatic void build_schedule();
        logic [63:0] m;
        logic [63:0] k;
        logic [63:0] nl;
        logic [63:0] step;
        logic [63:0] l [3];
        int          n;
        int          ra;
        int          rb;
        m  = word_mask(wide_mode);
        n  = round_count(wide_mode);
        ra = wide_mode ? LARGE_ROT_A : SMALL_ROT_A;
        rb = wide_mode ? LARGE_ROT_B : SMALL_ROT_B;
        k  = key_word[0] & m;
        for (int j = 0; j < 3; j++)
            l[j] = key_word[j + 1] & m;
        sched[0] = k;
        for (int i = 0; i + 1 < n; i++)
        begin
            step = 64'(i);
            nl = ((k + rot_right(wide_mode, l[0], ra)) & m) ^ step;
            k  = rot_left(wide_mode, k, rb) ^ nl;
            l[0] = l[1];
            l[1] = l[2];
            l[2] = nl;
            sched[i + 1] = k;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic speck_pair_t cipher_block(input logic [63:0] bx, input logic [63:0] by);
        speck_pair_t r;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] k;
        int          n;
        int          ra;
        int          rb;
        // expand the keys on the first block after reset or a write to a known register
        if (!sched_valid)
            build_schedule();
        m  = word_mask(wide_mode);
        n  = round_count(wide_mode);
        ra = wide_mode ? LARGE_ROT_A : SMALL_ROT_A;
        rb = wide_mode ? LARGE_ROT_B : SMALL_ROT_B;
        x  = bx & m;
        y  = by & m;
        if (decipher)
        begin
            for (int i = n - 1; i >= 0; i--)
            begin
                k = sched[i] & m;
                y = rot_right(wide_mode, x ^ y, rb);
                x = rot_left(wide_mode, ((x ^ k) - y) & m, ra);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                k = sched[i] & m;
                x = ((rot_right(wide_mode, x, ra) + y) & m) ^ k;
                y = rot_left(wide_mode, y, rb) ^ x;
            end
        end
        r.x = x & m;
        r.y = y & m;
        return r;
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [63:0] data);
        unique case (idx)
            REG_VARIANT: wide_mode = data[0];
            REG_DECRYPT: decipher = data[0];
            REG_KEY_0:   key_word[0] = data;
            REG_KEY_1:   key_word[1] = data;
            REG_KEY_2:   key_word[2] = data;
            REG_KEY_3:   key_word[3] = data;
            default:     ;
        endcase
        // writes past the register list leave the schedule alone
        if (idx < NUM_REGS)
            sched_valid = 1'b0;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode   = 1'b0;
            decipher    = 1'b0;
            sched_valid = 1'b0;
            for (int j = 0; j < 4; j++)
                key_word[j] = '0;
            cipher_results_due.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
                cipher_results_due.push_back(cipher_block(block_x, block_y));
            if (out_valid && out_ready)
            begin
                if (cipher_results_due.size() == 0)
                    report("result transfer with no block outstanding", result_x, '0);
                else
                begin
                    speck_pair_t due;
                    due = cipher_results_due.pop_front();
                    if (result_x !== due.x)
                        report("result_x", result_x, due.x);
                    if (result_y !== due.y)
                        report("result_y", result_y, due.y);
                end
            end
            pending = cipher_results_due.size();
        end
    end

endmodule

// ===== test/speck_block_cipher_test.sv =====
// Top of the Speck block cipher testbench: clock, reset, stimulus and verdict.
module speck_block_cipher_test import speck_pkg::*;;

    localparam int KEY_DEPTH     = 34;
    localparam int STALL_LIMIT   = 2000;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 78;
    localparam int TAIL_CYCLES   = 80;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [63:0] block_x   = '0;
    logic [63:0] block_y   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [63:0] result_x;
    logic [63:0] result_y;

    int fail_count;
    int pending;
    int send_idle    = 0;
    int recv_idle    = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    speck_block_cipher #(.ROUND_KEY_DEPTH(KEY_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .block_x   (block_x),
        .block_y   (block_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_x  (result_x),
        .result_y  (result_y)
    );

    speck_block_cipher_checker #(.ROUND_KEY_DEPTH(KEY_DEPTH)) cipher_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .block_x    (block_x),
        .block_y    (block_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_x   (result_x),
        .result_y   (result_y),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_block_word();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {48'd0, 16'(rand64() >> 48)};
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] pick_key_word();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic send_block(input logic [63:0] x, input logic [63:0] y);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        block_x  <= x;
        block_y  <= y;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off until every result has come back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic wide, input logic dec, input logic [63:0] k0,
                             input logic [63:0] k1, input logic [63:0] k2,
                             input logic [63:0] k3, input logic stray);
        logic [63:0] filler;
        filler = rand64();
        write_reg(REG_VARIANT, {filler[63:1], wide});
        filler = rand64();
        write_reg(REG_DECRYPT, {filler[63:1], dec});
        write_reg(REG_KEY_0, k0);
        write_reg(REG_KEY_1, k1);
        write_reg(REG_KEY_2, k2);
        write_reg(REG_KEY_3, k3);
        if (stray)
            write_reg($urandom_range(1) ? NUM_REGS : NUM_REGS + 3'd1, rand64());
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: narrow words, encrypt, all-zero key, schedule not yet built
        send_block('0, '0);
        send_block('1, '1);
        drain();

        // narrow known-answer key with junk in the unused upper bits
        configure(1'b0, 1'b0, {48'(rand64() >> 16), 16'h0100},
                  {48'(rand64() >> 16), 16'h0908}, {48'(rand64() >> 16), 16'h1110},
                  {48'(rand64() >> 16), 16'h1918}, 1'b0);
        send_block(64'h6574, 64'h694c);
        send_block(64'hFFFF, 64'h0);
        send_block(64'h0, 64'hFFFF);
        send_block(rand64(), rand64());
        drain();

        configure(1'b0, 1'b1, 64'h0100, 64'h0908, 64'h1110, 64'h1918, 1'b0);
        send_block(64'ha868, 64'h42f2);
        send_block('1, '0);
        drain();

        configure(1'b1, 1'b0, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                  64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 1'b0);
        send_block(64'h65736f6420656874, 64'h2073756f6620676e);
        send_block('1, '1);
        send_block('0, '0);
        drain();

        // a lone mode write forces a fresh schedule with the same key
        write_reg(REG_DECRYPT, 64'd1);
        cfg_we <= 1'b0;
        send_block(64'h4109010405c0f53e, 64'h4eeeb48d9c188f43);
        drain();

        // writes past the register list change nothing
        write_reg(NUM_REGS, rand64());
        write_reg(NUM_REGS + 3'd1, rand64());
        cfg_we <= 1'b0;
        send_block(rand64(), rand64());
        drain();

        configure(1'b1, 1'b1, '1, '1, '1, '1, 1'b0);
        send_block(rand64(), rand64());
        drain();
        configure(1'b0, 1'b1, '0, '0, '0, '0, 1'b0);
        send_block(rand64(), rand64());
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle = (seg < 4) ? 24 : (seg < 8) ? 46 : 0;
            recv_idle <= (seg < 4) ? 46 : (seg < 8) ? 24 : 0;
            configure(seg[0], seg[1], pick_key_word(), pick_key_word(), pick_key_word(),
                      pick_key_word(), $urandom_range(3) == 0);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_block(pick_block_word(), pick_block_word());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
